// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// No dependencies; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/uhc_pkg.sv =====
// Shared types, constants and the CRC-32 byte step for the upgrade header checker.
// No dependencies.
package uhc_pkg;

    localparam int HEADER_MAX_DEF = 256;
    localparam int DIGEST_BYTES   = 20;
    localparam int DESC_MAX       = 128;
    localparam int DIG_AW         = $clog2(DIGEST_BYTES);

    localparam logic [31:0] HDR_MIN      = 32'd40;
    localparam logic [31:0] VER_END      = 32'd4;
    localparam logic [31:0] LEN_END      = 32'd8;
    localparam logic [31:0] LEN_LAST     = 32'd7;
    localparam logic [31:0] SIZE_END     = 32'd12;
    localparam logic [31:0] DIGEST_START = 32'd12;
    localparam logic [31:0] DIGEST_END   = 32'(12 + DIGEST_BYTES);
    localparam logic [31:0] DESC_START   = 32'd32;
    localparam logic [31:0] DESC_END     = 32'(32 + DESC_MAX);
    localparam logic [31:0] CRC_LEN      = 32'd4;
    localparam logic [31:0] VERSION_OK   = 32'd1;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;

    typedef enum logic [3:0] {
        K_COLLECT  = 4'd0,
        K_HDR_OK   = 4'd1,
        K_DIGEST   = 4'd2,
        K_PAYLOAD  = 4'd3,
        K_BAD_SIZE = 4'd4,
        K_BAD_VER  = 4'd5,
        K_BAD_CRC  = 4'd6,
        K_BAD_DESC = 4'd7,
        K_REJECT   = 4'd8
    } t_kind;

    typedef struct packed {
        logic take;       // input request accepted, update state and load result
        logic dig_start;  // header-ok result taken, show first digest byte
        logic dig_next;   // digest byte taken, advance to the next one
    } t_cmd;

    typedef struct packed {
        logic hdr_ok;     // result on display is header ok
        logic dig_last;   // digest byte on display is the final one
    } t_status;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== design/uhc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module uhc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/uhc_dp.sv =====
// Datapath: header fields, CRC, terminator flag, digest store and result registers.
// Depends on uhc_pkg and uhc_ram.
module uhc_dp #(
    parameter int HEADER_MAX = uhc_pkg::HEADER_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  uhc_pkg::t_cmd    i_cmd,
    output uhc_pkg::t_status o_status,
    input  logic             i_mode,
    input  logic [7:0]       i_data_byte,
    output logic [3:0]       o_kind,
    output logic [7:0]       o_data_out,
    output logic [31:0]      o_image_size,
    output logic             o_last
);

    localparam int CW = $clog2(HEADER_MAX + 1);
    localparam int AW = uhc_pkg::DIG_AW;

    typedef enum logic [1:0] {
        PH_COLLECT = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_ERROR   = 2'd2
    } t_phase;

    t_phase       r_phase, n_phase;
    logic [CW-1:0] r_count, n_count;
    logic [31:0]  r_len, n_len;
    logic [31:0]  r_version, n_version;
    logic [31:0]  r_psize, n_psize;
    logic [31:0]  r_crc, n_crc;
    logic [31:0]  r_rcrc, n_rcrc;
    logic         r_term, n_term;
    logic [AW-1:0] r_dig_idx, n_dig_idx;

    uhc_pkg::t_kind r_kind, n_kind;
    logic [7:0]   r_data, n_data;
    logic [31:0]  r_size, n_size;
    logic         r_last, n_last;

    logic [31:0]  count_ext;
    logic [31:0]  waddr_full;
    logic         ram_we;
    logic [7:0]   ram_rdata;

    assign count_ext  = 32'(r_count);
    assign waddr_full = count_ext - uhc_pkg::DIGEST_START;

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_len     = r_len;
        n_version = r_version;
        n_psize   = r_psize;
        n_crc     = r_crc;
        n_rcrc    = r_rcrc;
        n_term    = r_term;
        n_kind    = uhc_pkg::K_COLLECT;
        n_data    = 8'd0;
        n_size    = 32'd0;
        n_last    = 1'b1;
        ram_we    = 1'b0;
        if (!i_mode) begin
            n_phase   = PH_COLLECT;
            n_count   = '0;
            n_len     = 32'd0;
            n_version = 32'd0;
            n_psize   = 32'd0;
            n_crc     = uhc_pkg::CRC_INIT;
            n_rcrc    = 32'd0;
            n_term    = 1'b0;
        end else if (r_phase == PH_PAYLOAD) begin
            n_kind = uhc_pkg::K_PAYLOAD;
            n_data = i_data_byte;
        end else if (r_phase != PH_COLLECT) begin
            n_kind = uhc_pkg::K_REJECT;
        end else begin
            n_count = r_count + 1'b1;
            if (count_ext < uhc_pkg::VER_END) begin
                n_version = {r_version[23:0], i_data_byte};
            end else if (count_ext < uhc_pkg::LEN_END) begin
                n_len = {r_len[23:0], i_data_byte};
            end else if (count_ext < uhc_pkg::SIZE_END) begin
                n_psize = {r_psize[23:0], i_data_byte};
            end else if (count_ext < uhc_pkg::DIGEST_END) begin
                ram_we = i_cmd.take;
            end
            // Bytes 0..7 always feed the CRC; the last four header bytes are the check value.
            if (count_ext < uhc_pkg::LEN_END || count_ext + uhc_pkg::CRC_LEN < r_len) begin
                n_crc = uhc_pkg::crc_byte(r_crc, i_data_byte);
            end else begin
                n_rcrc = {r_rcrc[23:0], i_data_byte};
            end
            if (i_data_byte == 8'd0 && count_ext >= uhc_pkg::DESC_START
                    && count_ext < uhc_pkg::DESC_END) begin
                n_term = 1'b1;
            end
            if (count_ext == uhc_pkg::LEN_LAST
                    && (n_len > 32'(HEADER_MAX) || n_len < uhc_pkg::HDR_MIN)) begin
                n_phase = PH_ERROR;
                n_kind  = uhc_pkg::K_BAD_SIZE;
            end else if (count_ext >= uhc_pkg::LEN_END && count_ext + 32'd1 == r_len) begin
                n_phase = PH_ERROR;
                if (r_version != uhc_pkg::VERSION_OK) begin
                    n_kind = uhc_pkg::K_BAD_VER;
                end else if (~n_crc != n_rcrc) begin
                    n_kind = uhc_pkg::K_BAD_CRC;
                end else if (!n_term) begin
                    n_kind = uhc_pkg::K_BAD_DESC;
                end else begin
                    n_phase = PH_PAYLOAD;
                    n_kind  = uhc_pkg::K_HDR_OK;
                    n_size  = r_psize;
                    n_last  = 1'b0;
                end
            end
        end
    end

    // Read address runs one step ahead so the registered read shows the current index.
    always_comb begin
        n_dig_idx = r_dig_idx;
        if (i_cmd.take) begin
            n_dig_idx = '0;
        end else if (i_cmd.dig_next) begin
            n_dig_idx = r_dig_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_COLLECT;
            r_count   <= '0;
            r_len     <= 32'd0;
            r_version <= 32'd0;
            r_psize   <= 32'd0;
            r_crc     <= uhc_pkg::CRC_INIT;
            r_rcrc    <= 32'd0;
            r_term    <= 1'b0;
            r_dig_idx <= '0;
        end else begin
            r_dig_idx <= n_dig_idx;
            if (i_cmd.take) begin
                r_phase   <= n_phase;
                r_count   <= n_count;
                r_len     <= n_len;
                r_version <= n_version;
                r_psize   <= n_psize;
                r_crc     <= n_crc;
                r_rcrc    <= n_rcrc;
                r_term    <= n_term;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_kind <= n_kind;
            r_data <= n_data;
            r_size <= n_size;
            r_last <= n_last;
        end else if (i_cmd.dig_start) begin
            r_kind <= uhc_pkg::K_DIGEST;
            r_data <= 8'd0;
            r_size <= 32'd0;
            r_last <= (r_dig_idx == AW'(uhc_pkg::DIGEST_BYTES - 1));
        end else if (i_cmd.dig_next) begin
            r_last <= (r_dig_idx == AW'(uhc_pkg::DIGEST_BYTES - 2));
        end
    end

    uhc_ram #(
        .WIDTH (8),
        .DEPTH (uhc_pkg::DIGEST_BYTES)
    ) u_digest_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr_full[AW-1:0]),
        .i_wdata (i_data_byte),
        .i_raddr (n_dig_idx),
        .o_rdata (ram_rdata)
    );

    assign o_status.hdr_ok   = (r_kind == uhc_pkg::K_HDR_OK);
    assign o_status.dig_last = (r_dig_idx == AW'(uhc_pkg::DIGEST_BYTES - 1));

    assign o_kind       = r_kind;
    assign o_data_out   = (r_kind == uhc_pkg::K_DIGEST) ? ram_rdata : r_data;
    assign o_image_size = r_size;
    assign o_last       = r_last;

endmodule

// ===== design/uhc_ctrl.sv =====
// Controller: sequences input requests, result display and the digest run.
// Depends on uhc_pkg.
module uhc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  uhc_pkg::t_status i_status,
    output uhc_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IN  = 2'd0,
        S_OUT = 2'd1,
        S_DIG = 2'd2
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   out_take;

    assign out_take = r_out_valid && i_out_ready;

    assign o_cmd.take      = (r_state == S_IN) && r_in_ready && i_in_valid;
    assign o_cmd.dig_start = (r_state == S_OUT) && out_take && i_status.hdr_ok;
    assign o_cmd.dig_next  = (r_state == S_DIG) && out_take && !i_status.dig_last;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IN: begin
                if (o_cmd.take) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_take) begin
                    n_state = i_status.hdr_ok ? S_DIG : S_IN;
                end
            end
            S_DIG: begin
                if (out_take && i_status.dig_last) begin
                    n_state = S_IN;
                end
            end
            default: n_state = S_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IN;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= (n_state == S_IN);
            r_out_valid <= (n_state != S_IN);
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

// ===== design/upgrade_header_checker_top.sv =====
// Upgrade header checker: top level joining controller and datapath.
// Depends on uhc_pkg, uhc_ctrl, uhc_dp (and uhc_ram below it).
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready) takes one request per item: mode 0
//    begins a new upload and clears all state, mode 1 carries the next image byte.
//  - Output channel (o_out_valid / i_out_ready) returns the results. Every request
//    yields one result, except the byte that completes a good header: it yields a
//    header-ok result carrying the image size, then the 20 digest bytes in order,
//    with o_last set only on the final digest byte.
//  - Timing: the result appears in the cycle after the request is accepted. The
//    block works on one request at a time: a request is accepted, then its results
//    are handed off, the header-completing request with its digest run. The bound
//    is the single result register shared by input and output, with one digest byte
//    shown per cycle from the digest RAM while the receiver is ready.
//  - CRC-32 of each byte before the check value is computed in the cycle it is taken.
//  - Errors latch: after a failed check every byte returns a rejected result until
//    the next begin request.
//  - Reset (i_rst_n low, synchronous) leaves the block as if a begin request had
//    just been handled, with no result pending and o_in_ready high.
//  - When the receiver stalls, hold the displayed result; no new request is taken
//    until every result of the current one has been delivered.
module upgrade_header_checker_top #(
    parameter int HEADER_MAX = uhc_pkg::HEADER_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_kind,
    output logic [7:0]  o_data_out,
    output logic [31:0] o_image_size,
    output logic        o_last
);

    uhc_pkg::t_cmd    cmd;
    uhc_pkg::t_status status;

    // Sequence requests and result handoff.
    uhc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Collect the header, run the checks, hold the result on display.
    uhc_dp #(
        .HEADER_MAX (HEADER_MAX)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_mode       (i_mode),
        .i_data_byte  (i_data_byte),
        .o_kind       (o_kind),
        .o_data_out   (o_data_out),
        .o_image_size (o_image_size),
        .o_last       (o_last)
    );

endmodule

// ===== design/uhc_checker.sv =====
// Port-level checker for the upgrade header checker, bound to the top level.
// Depends on uhc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module uhc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  o_kind,
    input logic [7:0]  o_data_out,
    input logic [31:0] o_image_size,
    input logic        o_last
);

    logic        in_take;
    logic        out_take;
    logic        ok_taken;
    logic        digest_shown;
    logic        single_shown;
    logic        stalled;
    logic [45:0] shown;

    assign in_take      = i_in_valid && o_in_ready;
    assign out_take     = o_out_valid && i_out_ready;
    assign ok_taken     = out_take && o_kind == uhc_pkg::K_HDR_OK;
    assign digest_shown = o_out_valid && o_kind == uhc_pkg::K_DIGEST;
    assign single_shown = o_out_valid && o_kind != uhc_pkg::K_HDR_OK
                          && o_kind != uhc_pkg::K_DIGEST;
    assign stalled      = o_out_valid && !i_out_ready;
    assign shown        = {o_out_valid, o_kind, o_data_out, o_image_size, o_last};

    `ASSERT_IMPLIES(a_one_side, i_clk, i_rst_n, o_out_valid, !o_in_ready, "both sides open")
    `ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, in_take, o_out_valid, "result missing")
    `ASSERT_NEXT(a_digest_next, i_clk, i_rst_n, ok_taken, digest_shown, "digest run missing")
    `ASSERT_IMPLIES(a_last_flag, i_clk, i_rst_n, single_shown, o_last, "last flag missing")
    `ASSERT_NEXT(a_hold_stall, i_clk, i_rst_n, stalled, $stable(shown), "result moved in stall")

endmodule

bind upgrade_header_checker_top uhc_checker u_uhc_checker (.*);
